>>> src/frt_pkg.sv
// Package with shared types and constants for the fragment reassembly tracker.
`timescale 1ns / 1ps
package frt_pkg;

    typedef enum logic [2:0] {
        ACT_ATTACH   = 3'd0,
        ACT_SAVED    = 3'd1,
        ACT_DUP      = 3'd2,
        ACT_RESAVED  = 3'd3,
        ACT_RANGE    = 3'd4,
        ACT_FULL     = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_DECIDE,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic search_start;
        logic search_step;
        logic read_slot;
        logic decide;
        logic drain_step;
        logic write_back;
        logic out_load;
    } frt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic reject;
        logic first_more;
        logic drain_more;
        logic out_busy;
    } frt_sts_t;

endpackage

>>> src/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker: controller plus datapath.
//
//   Channel   Signals                                              Role
//   input     valid, ready, msg_id, fragment_num, fragment_size,   fragment header request
//             is_last
//   output    out_valid, out_ready, out_msg_id, out_fragment_num,  result items
//             action, message_complete, ack_bits, last_of_run
//
// A request is worked by a table scan that checks one slot per cycle, then a slot read and
// a decision; each saved fragment drained gives one more result. A size or range reject
// ends the scan at once; a full table is found only after the whole scan. A reject writes
// nothing back. The first result is loaded at the decision step.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A stalled output holds the sequencer; one request is worked at a time.
`timescale 1ns / 1ps
module fragment_reassembly_tracker #(
    parameter int MSG_SLOTS         = 16,
    parameter int MAX_FRAGMENTS     = 64,
    parameter int MAX_FRAGMENT_SIZE = 1456
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [31:0] msg_id,
    input  logic [6:0]  fragment_num,
    input  logic [13:0] fragment_size,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_msg_id,
    output logic [6:0]  out_fragment_num,
    output logic [2:0]  action,
    output logic        message_complete,
    output logic [63:0] ack_bits,
    output logic        last_of_run
);
    import frt_pkg::*;

    frt_cmd_t cmd;
    frt_sts_t sts;

    frt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (valid),
        .ready (ready),
        .cmd   (cmd),
        .sts   (sts)
    );

    frt_dp #(
        .MSG_SLOTS         (MSG_SLOTS),
        .MAX_FRAGMENTS     (MAX_FRAGMENTS),
        .MAX_FRAGMENT_SIZE (MAX_FRAGMENT_SIZE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .msg_id           (msg_id),
        .fragment_num     (fragment_num),
        .fragment_size    (fragment_size),
        .is_last          (is_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_msg_id       (out_msg_id),
        .out_fragment_num (out_fragment_num),
        .action           (action),
        .message_complete (message_complete),
        .ack_bits         (ack_bits),
        .last_of_run      (last_of_run)
    );
endmodule

>>> src/frt_ctrl.sv
// Controller state machine sequencing search, slot read, decision, drain and write-back.
`timescale 1ns / 1ps
module frt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             ready,
    output frt_pkg::frt_cmd_t cmd,
    input  frt_pkg::frt_sts_t sts
);
    import frt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (valid) state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (sts.search_done) state_next = ST_READ;
            end
            ST_READ:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!sts.out_busy)
                begin
                    if (sts.reject)
                        state_next = ST_IDLE;
                    else
                        state_next = sts.first_more ? ST_DRAIN : ST_WRITE;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.out_busy) state_next = sts.drain_more ? ST_DRAIN : ST_WRITE;
            end
            ST_WRITE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd   = '0;
        ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready            = 1'b1;
                cmd.capture      = valid;
                cmd.search_start = valid;
            end
            ST_SEARCH: cmd.search_step = 1'b1;
            ST_READ:   cmd.read_slot = 1'b1;
            ST_DECIDE:
            begin
                cmd.decide   = !sts.out_busy;
                cmd.out_load = !sts.out_busy;
            end
            ST_DRAIN:
            begin
                cmd.drain_step = !sts.out_busy;
                cmd.out_load   = !sts.out_busy;
            end
            ST_WRITE:  cmd.write_back = 1'b1;
            default:   cmd = '0;
        endcase
    end
endmodule

>>> src/frt_dp.sv
// Datapath holding the slot table, search counter, slot working copy and output register.
`timescale 1ns / 1ps
module frt_dp #(
    parameter int MSG_SLOTS         = 16,
    parameter int MAX_FRAGMENTS     = 64,
    parameter int MAX_FRAGMENT_SIZE = 1456
) (
    input  logic              clk,
    input  logic              rst_n,
    input  frt_pkg::frt_cmd_t cmd,
    output frt_pkg::frt_sts_t sts,
    input  logic [31:0]       msg_id,
    input  logic [6:0]        fragment_num,
    input  logic [13:0]       fragment_size,
    input  logic              is_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_msg_id,
    output logic [6:0]        out_fragment_num,
    output logic [2:0]        action,
    output logic              message_complete,
    output logic [63:0]       ack_bits,
    output logic              last_of_run
);
    import frt_pkg::*;

    localparam int SW = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
    localparam int CW = $clog2(MSG_SLOTS + 1);
    localparam logic [6:0]  FRAG_LIMIT = 7'(MAX_FRAGMENTS);
    localparam logic [13:0] SIZE_LIMIT = 14'(MAX_FRAGMENT_SIZE);

    logic [MSG_SLOTS-1:0] valid_reg;
    logic [31:0]          id_mem [MSG_SLOTS];
    logic [6:0]           nxt_mem [MSG_SLOTS];
    logic [63:0]          rcv_mem [MSG_SLOTS];
    logic [63:0]          sav_mem [MSG_SLOTS];
    logic [63:0]          svl_mem [MSG_SLOTS];

    logic [31:0]   in_id_reg;
    logic [6:0]    in_num_reg;
    logic          in_last_reg;
    logic          in_bad_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] hit_reg, free_reg;
    logic          hit_found_reg, free_found_reg;
    logic [SW-1:0] slot_reg;
    logic          reject_reg;
    logic          done_reg;
    logic [6:0]    nxt_reg;
    logic [63:0]   rcv_reg, sav_reg, svl_reg;

    logic          oval_reg;
    logic [31:0]   oid_reg;
    logic [6:0]    onum_reg;
    action_t       oact_reg;
    logic          ocmp_reg, olast_reg;
    logic [63:0]   oack_reg;

    logic [SW-1:0] cidx;
    logic [5:0]    nbit, ibit;
    logic [6:0]    in_num_inc, nxt_inc;
    logic [63:0]   rcv_set;
    logic          search_done;
    logic          in_order;
    logic          first_more;
    logic          drain_more;

    assign cidx        = cnt_reg[SW-1:0];
    assign nbit        = nxt_reg[5:0];
    assign ibit        = in_num_reg[5:0];
    assign in_num_inc  = in_num_reg + 7'd1;
    assign nxt_inc     = nxt_reg + 7'd1;
    assign rcv_set     = rcv_reg | (64'd1 << ibit);
    assign search_done = (cnt_reg == CW'(MSG_SLOTS)) || in_bad_reg;
    assign in_order    = (in_num_reg == nxt_reg);
    assign first_more  = in_order && !in_last_reg && (in_num_inc < FRAG_LIMIT)
                         && sav_reg[in_num_inc[5:0]];
    assign drain_more  = !svl_reg[nbit] && (nxt_inc < FRAG_LIMIT) && sav_reg[nxt_inc[5:0]];

    always_comb
    begin
        sts.search_done = search_done;
        sts.reject      = reject_reg;
        sts.first_more  = first_more;
        sts.drain_more  = drain_more;
        sts.out_busy    = oval_reg && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_id_reg   <= msg_id;
            in_num_reg  <= fragment_num;
            in_last_reg <= is_last;
            in_bad_reg  <= (fragment_size >= SIZE_LIMIT) || (fragment_num >= FRAG_LIMIT);
        end
        if (cmd.search_start)
        begin
            cnt_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= '0;
            free_reg       <= '0;
        end
        else if (cmd.search_step && !search_done)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (valid_reg[cidx] && id_mem[cidx] == in_id_reg && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_reg       <= cidx;
            end
            if (!valid_reg[cidx] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_reg       <= cidx;
            end
        end
        if (cmd.read_slot)
        begin
            reject_reg <= in_bad_reg || (!hit_found_reg && !free_found_reg);
            slot_reg   <= hit_found_reg ? hit_reg : free_reg;
            done_reg   <= 1'b0;
            if (hit_found_reg)
            begin
                nxt_reg <= nxt_mem[hit_reg];
                rcv_reg <= rcv_mem[hit_reg];
                sav_reg <= sav_mem[hit_reg];
                svl_reg <= svl_mem[hit_reg];
            end
            else
            begin
                nxt_reg <= '0;
                rcv_reg <= '0;
                sav_reg <= '0;
                svl_reg <= '0;
            end
        end
        else if (cmd.decide && !reject_reg)
        begin
            rcv_reg  <= rcv_set;
            done_reg <= in_order && !first_more && in_last_reg;
            if (in_order)
            begin
                nxt_reg <= in_num_inc;
            end
            else if (in_num_reg > nxt_reg && !sav_reg[ibit])
            begin
                sav_reg[ibit] <= 1'b1;
                svl_reg[ibit] <= in_last_reg;
            end
        end
        else if (cmd.drain_step)
        begin
            sav_reg[nbit] <= 1'b0;
            svl_reg[nbit] <= 1'b0;
            nxt_reg       <= nxt_inc;
            done_reg      <= !drain_more && svl_reg[nbit];
        end
        if (cmd.write_back)
        begin
            id_mem[slot_reg]  <= in_id_reg;
            nxt_mem[slot_reg] <= nxt_reg;
            rcv_mem[slot_reg] <= rcv_reg;
            sav_mem[slot_reg] <= sav_reg;
            svl_mem[slot_reg] <= svl_reg;
        end
        if (cmd.out_load)
        begin
            oid_reg <= in_id_reg;
            if (cmd.decide)
            begin
                onum_reg <= in_num_reg;
                if (reject_reg)
                begin
                    oact_reg  <= in_bad_reg ? ACT_RANGE : ACT_FULL;
                    ocmp_reg  <= 1'b0;
                    oack_reg  <= '0;
                    olast_reg <= 1'b1;
                end
                else if (in_order)
                begin
                    oact_reg  <= ACT_ATTACH;
                    ocmp_reg  <= !first_more && in_last_reg;
                    oack_reg  <= (!first_more && !in_last_reg) ? rcv_set : 64'd0;
                    olast_reg <= !first_more;
                end
                else if (in_num_reg < nxt_reg)
                begin
                    oact_reg  <= ACT_DUP;
                    ocmp_reg  <= 1'b0;
                    oack_reg  <= rcv_set;
                    olast_reg <= 1'b1;
                end
                else
                begin
                    oact_reg  <= sav_reg[ibit] ? ACT_RESAVED : ACT_SAVED;
                    ocmp_reg  <= 1'b0;
                    oack_reg  <= rcv_set;
                    olast_reg <= 1'b1;
                end
            end
            else
            begin
                onum_reg  <= nxt_reg;
                oact_reg  <= ACT_ATTACH;
                ocmp_reg  <= !drain_more && svl_reg[nbit];
                oack_reg  <= (!drain_more && !svl_reg[nbit]) ? rcv_reg : 64'd0;
                olast_reg <= !drain_more;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write_back)
            begin
                valid_reg[slot_reg] <= !done_reg;
            end
            if (cmd.out_load)
            begin
                oval_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = oval_reg;
    assign out_msg_id       = oid_reg;
    assign out_fragment_num = onum_reg;
    assign action           = oact_reg;
    assign message_complete = ocmp_reg;
    assign ack_bits         = oack_reg;
    assign last_of_run      = olast_reg;
endmodule
